// ===== design/stq_pkg.sv =====
// types, codes and constants shared by the sorted timer queue
`default_nettype none

package stq_pkg;

  localparam int unsigned TIME_W  = 48;
  localparam int unsigned IVL_W   = 32;
  localparam int unsigned ID_W    = 8;
  localparam int unsigned DELAY_W = 31;
  localparam int unsigned LEAD_W  = 20;
  localparam int unsigned MAX_RES = 32;
  localparam int unsigned RES_CW  = 6;

  localparam logic [LEAD_W-1:0]  LEAD_RST  = 20'd100;
  localparam logic [TIME_W-1:0]  TIME_MAX  = 48'hFFFF_FFFF_FFFF;
  localparam logic [DELAY_W-1:0] DELAY_MAX = 31'h7FFF_FFFF;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [1:0] KIND_FIRED = 2'd0;
  localparam logic [1:0] KIND_ALARM = 2'd1;
  localparam logic [1:0] KIND_FULL  = 2'd2;

  typedef struct packed {
    logic              op;
    logic [ID_W-1:0]   timer_id;
    logic [TIME_W-1:0] when_us;
    logic [IVL_W-1:0]  interval_us;
    logic [TIME_W-1:0] now_us;
  } in_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [ID_W-1:0]    fired_id;
    logic [DELAY_W-1:0] delay_us;
    logic               last;
  } out_t;

  // one table entry
  typedef struct packed {
    logic [TIME_W-1:0] expiry;
    logic [IVL_W-1:0]  interval;
    logic [ID_W-1:0]   handle;
  } entry_t;

  // expired timer kept for re-insertion
  typedef struct packed {
    logic [IVL_W-1:0] interval;
    logic [ID_W-1:0]  handle;
  } xent_t;

  // request from the sequencer to the result stage
  typedef struct packed {
    logic valid;
    logic fin;
    out_t res;
  } emit_req_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FULL,
    S_PLACE,
    S_I_RD,
    S_I_EV,
    S_I_LAST,
    S_SC_CHK,
    S_SC_EV,
    S_CP_CHK,
    S_CP_WR,
    S_R_CHK,
    S_R_EV,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== design/sorted_timer_queue.sv =====
// sorted timer queue: timers kept in expiry order in one ram, scanned entry by entry with a
// read state and an evaluate state; an add shifts later entries up to place the new one; a tick
// scans and fires expired entries, compacts the table, then puts each repeating timer back by
// the same placement and drops each one-shot, all through the single table read port; one
// item is in work at a time, results leave through a pending stage and an output register
// reset is synchronous: live count cleared, minimum lead back to 100 us, table contents
// undefined and never read before written
`default_nettype none

module sorted_timer_queue #(
  parameter int unsigned SLOTS = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire stq_pkg::in_t               in_data,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output stq_pkg::out_t                   out_data,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [stq_pkg::LEAD_W-1:0] cfg_data
);

  localparam int unsigned AW = $clog2(SLOTS);
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned EW = $bits(stq_pkg::entry_t);
  localparam int unsigned XW = $bits(stq_pkg::xent_t);

  stq_pkg::state_t               state_r, state_nxt;
  logic [CW-1:0]                 live_r, live_nxt;
  logic [CW-1:0]                 k_r, k_nxt;
  logic [CW-1:0]                 idx_r, idx_nxt;
  logic [CW-1:0]                 j_r, j_nxt;
  logic                          op_r, op_nxt;
  logic [stq_pkg::TIME_W-1:0]    now_r, now_nxt;
  stq_pkg::entry_t               ins_r, ins_nxt;
  logic [stq_pkg::LEAD_W-1:0]    min_lead_r;

  logic                          tbl_we, tbl_re;
  logic [AW-1:0]                 tbl_waddr, tbl_raddr;
  stq_pkg::entry_t               tbl_wdata;
  logic [EW-1:0]                 tbl_rbits;
  stq_pkg::entry_t               tbl_q;
  logic                          xq_we, xq_re;
  logic [AW-1:0]                 xq_waddr, xq_raddr;
  stq_pkg::xent_t                xq_wdata;
  logic [XW-1:0]                 xq_rbits;
  stq_pkg::xent_t                xq_q;

  stq_pkg::emit_req_t            emit;
  logic                          grant;
  logic [stq_pkg::DELAY_W-1:0]   delay_w;

  logic [CW-1:0]                 idx_inc, idx_dec, cp_dst;
  logic [stq_pkg::TIME_W:0]      re_sum;
  logic [stq_pkg::TIME_W-1:0]    re_exp;
  logic                          place_ret_add;

  assign tbl_q     = stq_pkg::entry_t'(tbl_rbits);
  assign xq_q      = stq_pkg::xent_t'(xq_rbits);
  assign idx_inc   = idx_r + CW'(1);
  assign idx_dec   = idx_r - CW'(1);
  assign cp_dst    = idx_r - k_r;
  assign re_sum    = {1'b0, now_r} + (stq_pkg::TIME_W + 1)'(xq_q.interval);
  assign re_exp    = re_sum[stq_pkg::TIME_W] ? stq_pkg::TIME_MAX : re_sum[stq_pkg::TIME_W-1:0];
  assign place_ret_add = (op_r == stq_pkg::OP_ADD);
  assign in_ready  = (state_r == stq_pkg::S_IDLE);
  assign cfg_ready = 1'b1;

  stq_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .re    (tbl_re),
    .raddr (tbl_raddr),
    .rdata (tbl_rbits)
  );

  stq_ram #(.WIDTH(XW), .DEPTH(SLOTS)) u_expired (
    .clk   (clk),
    .we    (xq_we),
    .waddr (xq_waddr),
    .wdata (xq_wdata),
    .re    (xq_re),
    .raddr (xq_raddr),
    .rdata (xq_rbits)
  );

  stq_lead u_lead (
    .clk      (clk),
    .expiry   (ins_r.expiry),
    .now      (now_r),
    .min_lead (min_lead_r),
    .delay_r  (delay_w)
  );

  stq_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (emit),
    .grant     (grant),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always_comb begin
    state_nxt = state_r;
    live_nxt  = live_r;
    k_nxt     = k_r;
    idx_nxt   = idx_r;
    j_nxt     = j_r;
    op_nxt    = op_r;
    now_nxt   = now_r;
    ins_nxt   = ins_r;
    tbl_we    = 1'b0;
    tbl_waddr = idx_inc[AW-1:0];
    tbl_wdata = ins_r;
    tbl_re    = 1'b0;
    tbl_raddr = idx_r[AW-1:0];
    xq_we     = 1'b0;
    xq_waddr  = k_r[AW-1:0];
    xq_wdata  = '{interval: tbl_q.interval, handle: tbl_q.handle};
    xq_re     = 1'b0;
    xq_raddr  = j_r[AW-1:0];
    emit      = '0;
    unique case (state_r)
      stq_pkg::S_IDLE: begin
        if (in_valid) begin
          op_nxt  = in_data.op;
          now_nxt = in_data.now_us;
          ins_nxt = '{expiry: in_data.when_us, interval: in_data.interval_us,
                      handle: in_data.timer_id};
          k_nxt   = '0;
          if (in_data.op == stq_pkg::OP_TICK) begin
            state_nxt = stq_pkg::S_SC_CHK;
          end else if (live_r >= CW'(SLOTS)) begin
            state_nxt = stq_pkg::S_FULL;
          end else begin
            state_nxt = stq_pkg::S_PLACE;
          end
        end
      end
      stq_pkg::S_FULL: begin
        emit.valid        = 1'b1;
        emit.res.kind     = stq_pkg::KIND_FULL;
        emit.res.fired_id = ins_r.handle;
        if (grant) begin
          state_nxt = stq_pkg::S_DONE;
        end
      end
      stq_pkg::S_PLACE: begin
        if (live_r == '0) begin
          state_nxt = stq_pkg::S_I_LAST;
        end else begin
          idx_nxt   = live_r - CW'(1);
          state_nxt = stq_pkg::S_I_RD;
        end
      end
      stq_pkg::S_I_RD: begin
        tbl_re    = 1'b1;
        state_nxt = stq_pkg::S_I_EV;
      end
      stq_pkg::S_I_EV: begin
        tbl_we = 1'b1;
        // later entries move up one place; equal expiries stay ahead of the new one
        if (tbl_q.expiry > ins_r.expiry) begin
          tbl_wdata = tbl_q;
          if (idx_r == '0) begin
            state_nxt = stq_pkg::S_I_LAST;
          end else begin
            idx_nxt   = idx_dec;
            state_nxt = stq_pkg::S_I_RD;
          end
        end else begin
          live_nxt  = live_r + CW'(1);
          state_nxt = place_ret_add ? stq_pkg::S_DONE : stq_pkg::S_R_CHK;
        end
      end
      stq_pkg::S_I_LAST: begin
        // new head: program the alarm
        emit.valid        = 1'b1;
        emit.res.kind     = stq_pkg::KIND_ALARM;
        emit.res.delay_us = delay_w;
        if (grant) begin
          tbl_we    = 1'b1;
          tbl_waddr = '0;
          live_nxt  = live_r + CW'(1);
          state_nxt = place_ret_add ? stq_pkg::S_DONE : stq_pkg::S_R_CHK;
        end
      end
      stq_pkg::S_SC_CHK: begin
        if (k_r < live_r) begin
          tbl_re    = 1'b1;
          tbl_raddr = k_r[AW-1:0];
          state_nxt = stq_pkg::S_SC_EV;
        end else begin
          idx_nxt   = k_r;
          state_nxt = stq_pkg::S_CP_CHK;
        end
      end
      stq_pkg::S_SC_EV: begin
        if (tbl_q.expiry <= now_r) begin
          emit.valid        = 1'b1;
          emit.res.kind     = stq_pkg::KIND_FIRED;
          emit.res.fired_id = tbl_q.handle;
          if (grant) begin
            xq_we     = 1'b1;
            k_nxt     = k_r + CW'(1);
            state_nxt = stq_pkg::S_SC_CHK;
          end
        end else begin
          idx_nxt   = k_r;
          state_nxt = stq_pkg::S_CP_CHK;
        end
      end
      stq_pkg::S_CP_CHK: begin
        if (idx_r < live_r) begin
          tbl_re    = 1'b1;
          state_nxt = stq_pkg::S_CP_WR;
        end else begin
          live_nxt  = live_r - k_r;
          j_nxt     = '0;
          state_nxt = stq_pkg::S_R_CHK;
        end
      end
      stq_pkg::S_CP_WR: begin
        tbl_we    = 1'b1;
        tbl_waddr = cp_dst[AW-1:0];
        tbl_wdata = tbl_q;
        idx_nxt   = idx_inc;
        state_nxt = stq_pkg::S_CP_CHK;
      end
      stq_pkg::S_R_CHK: begin
        if (j_r < k_r) begin
          xq_re     = 1'b1;
          state_nxt = stq_pkg::S_R_EV;
        end else begin
          state_nxt = stq_pkg::S_DONE;
        end
      end
      stq_pkg::S_R_EV: begin
        j_nxt = j_r + CW'(1);
        if (xq_q.interval != '0 && live_r < CW'(SLOTS)) begin
          ins_nxt   = '{expiry: re_exp, interval: xq_q.interval, handle: xq_q.handle};
          state_nxt = stq_pkg::S_PLACE;
        end else begin
          state_nxt = stq_pkg::S_R_CHK;
        end
      end
      stq_pkg::S_DONE: begin
        emit.valid = 1'b1;
        emit.fin   = 1'b1;
        if (grant) begin
          state_nxt = stq_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = stq_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= stq_pkg::S_IDLE;
      live_r  <= '0;
    end else begin
      state_r <= state_nxt;
      live_r  <= live_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_lead_r <= stq_pkg::LEAD_RST;
    end else if (cfg_valid) begin
      min_lead_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    k_r   <= k_nxt;
    idx_r <= idx_nxt;
    j_r   <= j_nxt;
    op_r  <= op_nxt;
    now_r <= now_nxt;
    ins_r <= ins_nxt;
  end

  a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= CW'(SLOTS))
    else $error("live count beyond table size");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_we |-> (CW'(tbl_waddr) <= live_r))
    else $error("table write beyond the live entries");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r != stq_pkg::S_IDLE))
    else $error("accepted transaction not taken into work");

  a_emit_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    emit.valid |-> (state_r != stq_pkg::S_IDLE))
    else $error("result requested while idle");

endmodule

`default_nettype wire

// ===== design/stq_ram.sv =====
// simple dual-port synchronous ram, one write and one registered read
`default_nettype none

module stq_ram #(
  parameter int unsigned WIDTH = 88,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/stq_lead.sv =====
// alarm delay: expiry minus now, floored at the minimum lead, saturated to 31 bits
`default_nettype none

module stq_lead (
  input  wire logic                          clk,
  input  wire logic [stq_pkg::TIME_W-1:0]    expiry,
  input  wire logic [stq_pkg::TIME_W-1:0]    now,
  input  wire logic [stq_pkg::LEAD_W-1:0]    min_lead,
  output logic      [stq_pkg::DELAY_W-1:0]   delay_r
);

  logic [stq_pkg::TIME_W:0]     diff;
  logic [stq_pkg::TIME_W-1:0]   ahead;
  logic [stq_pkg::DELAY_W-1:0]  delay_nxt;

  always_comb begin
    diff  = {1'b0, expiry} - {1'b0, now};
    // borrow or zero means already due
    ahead = diff[stq_pkg::TIME_W] ? '0 : diff[stq_pkg::TIME_W-1:0];
    priority if (ahead < stq_pkg::TIME_W'(min_lead)) begin
      delay_nxt = stq_pkg::DELAY_W'(min_lead);
    end else if (ahead > stq_pkg::TIME_W'(stq_pkg::DELAY_MAX)) begin
      delay_nxt = stq_pkg::DELAY_MAX;
    end else begin
      delay_nxt = ahead[stq_pkg::DELAY_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    delay_r <= delay_nxt;
  end

endmodule

`default_nettype wire

// ===== design/stq_emit.sv =====
// result stage: holds one pending result so the final one can carry last
`default_nettype none

module stq_emit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire stq_pkg::emit_req_t req,
  output logic                    grant,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output stq_pkg::out_t           out_data
);

  logic                       out_valid_r, out_valid_nxt;
  stq_pkg::out_t              out_data_r, out_data_nxt;
  logic                       pend_vld_r, pend_vld_nxt;
  stq_pkg::out_t              pend_r, pend_nxt;
  logic [stq_pkg::RES_CW-1:0] cnt_r, cnt_nxt;
  logic                       out_free;
  logic                       drop;

  assign out_free  = !out_valid_r || out_ready;
  assign drop      = cnt_r >= stq_pkg::RES_CW'(stq_pkg::MAX_RES);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    pend_vld_nxt  = pend_vld_r;
    pend_nxt      = pend_r;
    cnt_nxt       = cnt_r;
    grant         = 1'b0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (req.valid) begin
      if (req.fin) begin
        grant = !pend_vld_r || out_free;
        if (grant) begin
          if (pend_vld_r) begin
            out_data_nxt      = pend_r;
            out_data_nxt.last = 1'b1;
            out_valid_nxt     = 1'b1;
          end
          pend_vld_nxt = 1'b0;
          cnt_nxt      = '0;
        end
      end else begin
        grant = drop || !pend_vld_r || out_free;
        // past the result cap the request is granted and dropped
        if (grant && !drop) begin
          if (pend_vld_r) begin
            out_data_nxt      = pend_r;
            out_data_nxt.last = 1'b0;
            out_valid_nxt     = 1'b1;
          end
          pend_nxt     = req.res;
          pend_vld_nxt = 1'b1;
          cnt_nxt      = cnt_r + stq_pkg::RES_CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_vld_r  <= 1'b0;
      cnt_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      pend_vld_r  <= pend_vld_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    pend_r     <= pend_nxt;
  end

endmodule

`default_nettype wire
